// ===== sv/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types and constants of the parameter fragment decoder.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int MAX_PARAMS_DEF      = 5;
  localparam int MAX_PARAM_BYTES_DEF = 256;

  // results one message byte can cause
  localparam int MAX_RESULTS = 3;
  localparam int RES_CNT_W   = 2;

  // slot counter holds up to 15 closed parameters
  localparam int SLOT_CNT_W  = 4;

  localparam logic [7:0] FRAG_LEN_MASK = 8'o077;
  localparam logic [7:0] FRAG_LAST_BIT = 8'o200;

  typedef enum logic [1:0] {
    KIND_TYPE  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_DONE  = 2'd3
  } pfd_kind_t;

  typedef struct packed {
    pfd_kind_t   kind;
    logic [2:0]  slot;
    logic [7:0]  byte_value;
    logic [8:0]  length;
    logic [2:0]  seen;
    logic        run_end;
  } pfd_result_t;

  typedef pfd_result_t [MAX_RESULTS-1:0] pfd_res_vec_t;

  function automatic pfd_result_t make_result(pfd_kind_t kind, logic [2:0] slot,
                                              logic [7:0] value, logic [8:0] length,
                                              logic [2:0] seen);
    pfd_result_t r;
    r.kind       = kind;
    r.slot       = slot;
    r.byte_value = value;
    r.length     = length;
    r.seen       = seen;
    r.run_end    = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/pfd_parser.sv =====
// ----------------------------------------------------------------------------
// pfd_parser
// Message parse state and the results caused by one accepted byte.
// ----------------------------------------------------------------------------
module pfd_parser import pfd_pkg::*; #(
  parameter int MAX_PARAMS      = MAX_PARAMS_DEF,
  parameter int MAX_PARAM_BYTES = MAX_PARAM_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           msg_byte,
  input  logic                 final_byte,
  output pfd_res_vec_t         res,
  output logic [RES_CNT_W-1:0] res_cnt
);

  localparam logic [SLOT_CNT_W-1:0] SLOT_LIMIT = SLOT_CNT_W'(MAX_PARAMS);
  localparam logic [8:0]            BYTE_LIMIT = 9'(MAX_PARAM_BYTES);

  typedef enum logic [1:0] {
    PH_TYPE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2,
    PH_IGNORE = 2'd3
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [SLOT_CNT_W-1:0] slot_r, slot_nxt;
  logic [5:0]            left_r, left_nxt;
  logic                  final_r, final_nxt;
  logic [8:0]            stored_r, stored_nxt;
  logic                  open_r, open_nxt;

  always_comb begin
    logic [9:0] padded;
    phase_nxt  = phase_r;
    slot_nxt   = slot_r;
    left_nxt   = left_r;
    final_nxt  = final_r;
    stored_nxt = stored_r;
    open_nxt   = open_r;
    res        = '0;
    res_cnt    = '0;
    padded     = '0;

    unique case (phase_r)
      PH_TYPE: begin
        res[res_cnt] = make_result(KIND_TYPE, 3'd0, msg_byte, 9'd0, slot_nxt[2:0]);
        res_cnt      = res_cnt + 2'd1;
        phase_nxt    = PH_HEADER;
      end
      PH_HEADER: begin
        if (msg_byte == 8'd0) begin
          if (open_nxt) begin
            res[res_cnt] = make_result(KIND_CLOSE, slot_nxt[2:0], 8'd0, stored_nxt,
                                       3'(slot_nxt + 1'b1));
            res_cnt    = res_cnt + 2'd1;
            slot_nxt   = slot_nxt + 1'b1;
            open_nxt   = 1'b0;
            stored_nxt = '0;
            left_nxt   = '0;
            final_nxt  = 1'b0;
          end
          phase_nxt = PH_IGNORE;
        end else if (!open_nxt && slot_nxt >= SLOT_LIMIT) begin
          phase_nxt = PH_IGNORE;
        end else begin
          if (!open_nxt) begin
            open_nxt   = 1'b1;
            stored_nxt = '0;
          end
          left_nxt  = 6'(msg_byte & FRAG_LEN_MASK);
          final_nxt = |(msg_byte & FRAG_LAST_BIT);
          if (left_nxt == 6'd0) begin
            // empty fragment: closes at once when marked last
            if (final_nxt) begin
              res[res_cnt] = make_result(KIND_CLOSE, slot_nxt[2:0], 8'd0, stored_nxt,
                                         3'(slot_nxt + 1'b1));
              res_cnt    = res_cnt + 2'd1;
              slot_nxt   = slot_nxt + 1'b1;
              open_nxt   = 1'b0;
              stored_nxt = '0;
              left_nxt   = '0;
              final_nxt  = 1'b0;
            end
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (stored_nxt < BYTE_LIMIT) begin
          res[res_cnt] = make_result(KIND_BYTE, slot_nxt[2:0], msg_byte, 9'd0,
                                     slot_nxt[2:0]);
          res_cnt    = res_cnt + 2'd1;
          stored_nxt = stored_nxt + 9'd1;
        end
        left_nxt = left_nxt - 6'd1;
        if (left_nxt == 6'd0) begin
          phase_nxt = PH_HEADER;
          if (final_nxt) begin
            res[res_cnt] = make_result(KIND_CLOSE, slot_nxt[2:0], 8'd0, stored_nxt,
                                       3'(slot_nxt + 1'b1));
            res_cnt    = res_cnt + 2'd1;
            slot_nxt   = slot_nxt + 1'b1;
            open_nxt   = 1'b0;
            stored_nxt = '0;
            left_nxt   = '0;
            final_nxt  = 1'b0;
          end
        end
      end
      default: ;
    endcase

    if (final_byte) begin
      if (phase_nxt == PH_DATA && left_nxt != 6'd0) begin
        // cut-short fragment: missing bytes count as padding, saturated
        padded     = {1'b0, stored_nxt} + {4'd0, left_nxt};
        stored_nxt = (padded > {1'b0, BYTE_LIMIT}) ? BYTE_LIMIT : padded[8:0];
        res[res_cnt] = make_result(KIND_CLOSE, slot_nxt[2:0], 8'd0, stored_nxt,
                                   3'(slot_nxt + 1'b1));
        res_cnt  = res_cnt + 2'd1;
        slot_nxt = slot_nxt + 1'b1;
      end else if (open_nxt) begin
        res[res_cnt] = make_result(KIND_CLOSE, slot_nxt[2:0], 8'd0, stored_nxt,
                                   3'(slot_nxt + 1'b1));
        res_cnt  = res_cnt + 2'd1;
        slot_nxt = slot_nxt + 1'b1;
      end
      res[res_cnt] = make_result(KIND_DONE, 3'd0, 8'd0, 9'd0, slot_nxt[2:0]);
      res_cnt    = res_cnt + 2'd1;
      phase_nxt  = PH_TYPE;
      slot_nxt   = '0;
      left_nxt   = '0;
      final_nxt  = 1'b0;
      stored_nxt = '0;
      open_nxt   = 1'b0;
    end

    if (res_cnt != '0) begin
      res[res_cnt - 2'd1].run_end = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      slot_r   <= '0;
      left_r   <= '0;
      final_r  <= 1'b0;
      stored_r <= '0;
      open_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      slot_r   <= slot_nxt;
      left_r   <= left_nxt;
      final_r  <= final_nxt;
      stored_r <= stored_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule

// ===== sv/pfd_out_queue.sv =====
// ----------------------------------------------------------------------------
// pfd_out_queue
// Result register: holds the results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module pfd_out_queue import pfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  pfd_res_vec_t         load_res,
  input  logic [RES_CNT_W-1:0] load_cnt,
  input  logic                 out_stall,
  output logic                 out_valid,
  output pfd_result_t          head,
  output logic                 can_load
);

  pfd_res_vec_t         entry_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic                 take;

  assign out_valid = cnt_r != '0;
  assign head      = entry_r[0];
  assign take      = out_valid && !out_stall;
  // room for a new byte once the last held result leaves
  assign can_load  = (cnt_r == '0) || (cnt_r == RES_CNT_W'(1) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= load_res;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        entry_r[i] <= entry_r[i+1];
      end
    end
  end

endmodule

// ===== sv/parameter_fragment_decoder.sv =====
// ----------------------------------------------------------------------------
// parameter_fragment_decoder
// Decodes a fragmented parameter control message, one byte per transaction.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | msg_byte, final_byte
//   out_    | output    | out_valid / out_stall| kind, slot, byte, length, seen, run_end
//
// One byte per cycle when not stalled; a byte that causes k results (0 to 3)
// stalls the input (not for 0 or 1 while out_stall is low) while the single
// result register drains one per cycle; out_stall holds the drain and the input.
// The first result shows in the cycle after its byte is accepted.
// A new byte is taken in the cycle the last pending result leaves.
// rst_n clears the parse state and drops all pending results.
// ----------------------------------------------------------------------------
module parameter_fragment_decoder import pfd_pkg::*; #(
  parameter int MAX_PARAMS      = MAX_PARAMS_DEF,
  parameter int MAX_PARAM_BYTES = MAX_PARAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_msg_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [2:0] out_param_slot,
  output logic [7:0] out_byte_value,
  output logic [8:0] out_param_length,
  output logic [2:0] out_params_seen,
  output logic       out_run_end
);

  pfd_res_vec_t         res;
  logic [RES_CNT_W-1:0] res_cnt;
  pfd_result_t          head;
  logic                 can_load;
  logic                 accept;

  assign in_stall = !can_load;
  assign accept   = in_valid && can_load;

  pfd_parser #(
    .MAX_PARAMS      (MAX_PARAMS),
    .MAX_PARAM_BYTES (MAX_PARAM_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .msg_byte   (in_msg_byte),
    .final_byte (in_final_byte),
    .res        (res),
    .res_cnt    (res_cnt)
  );

  pfd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_res  (res),
    .load_cnt  (res_cnt),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .can_load  (can_load)
  );

  assign out_result_kind  = head.kind;
  assign out_param_slot   = head.slot;
  assign out_byte_value   = head.byte_value;
  assign out_param_length = head.length;
  assign out_params_seen  = head.seen;
  assign out_run_end      = head.run_end;

endmodule

// ===== sv/pfd_checker.sv =====
// ----------------------------------------------------------------------------
// pfd_checker
// Port-level checks of the parameter fragment decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pfd_checker import pfd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_final_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic [2:0] out_param_slot,
  input logic [7:0] out_byte_value,
  input logic [8:0] out_param_length,
  input logic [2:0] out_params_seen,
  input logic       out_run_end
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
      $stable(out_param_slot) && $stable(out_byte_value) &&
      $stable(out_param_length) && $stable(out_params_seen) && $stable(out_run_end))
    else $error("stalled result changed");

  // input only held back while results are pending
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // accepted last byte always leaves a result pending
  a_final_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_byte |=> out_valid)
    else $error("no result after final byte");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_DONE |-> out_run_end)
    else $error("done result not last of its run");

  a_close_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_CLOSE |-> out_params_seen == out_param_slot + 3'd1)
    else $error("close count mismatch");

endmodule

bind parameter_fragment_decoder pfd_checker u_pfd_checker (.*);

// ===== sim/tb_parameter_fragment_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parameter_fragment_decoder
// Drives control messages byte by byte into the fragment decoder. It starts
// with a table of directed bytes, then sends random well-formed and broken
// messages, with idle bursts on both channels. Each expected result, from a
// table row or a built-in decoder, is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_parameter_fragment_decoder;
  import pfd_pkg::*;

  localparam int ITEM_TARGET = 430;
  localparam int QUIET_FROM  = 370;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {P_TYPE, P_HEADER, P_DATA, P_SKIP} parse_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       f;
  } msg_byte_t;

  typedef struct {
    logic [7:0] b;
    logic       f;
    bit         typed;
    pfd_kind_t  kind;
    logic [2:0] slot;
    logic [7:0] value;
    logic [8:0] len;
    logic [2:0] seen;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_msg_byte = 8'h00;
  logic       in_final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [2:0] out_param_slot;
  logic [7:0] out_byte_value;
  logic [8:0] out_param_length;
  logic [2:0] out_params_seen;
  logic       out_run_end;

  // decoder state mirrored by the predictor
  parse_phase_t ph = P_TYPE;
  int           slots_closed = 0;
  int           frag_left = 0;
  bit           frag_last = 1'b0;
  int           kept = 0;
  bit           open_slot = 1'b0;

  pfd_result_t  byte_results[$];
  pfd_result_t  pending_results[$];
  msg_byte_t    message[$];
  bit           bursts_on = 1'b1;
  int           mismatches = 0;
  int           cycles = 0;

  dir_row_t dir_rows [29] = '{
    '{8'hFF, 1'b0, 1'b1, KIND_TYPE,  3'd0, 8'hFF, 9'd0, 3'd0},
    '{8'h83, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h00, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'hFF, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'hAA, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h40, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'hC0, 1'b0, 1'b1, KIND_CLOSE, 3'd1, 8'h00, 9'd0, 3'd2},
    '{8'h02, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h55, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h01, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h85, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h7E, 1'b1, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h00, 1'b0, 1'b1, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h00, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h12, 1'b1, 1'b1, KIND_DONE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h3C, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h80, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h80, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h80, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h80, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h80, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h81, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h99, 1'b1, 1'b1, KIND_DONE,  3'd0, 8'h00, 9'd0, 3'd5},
    '{8'h01, 1'b1, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h80, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h01, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h10, 1'b0, 1'b0, KIND_TYPE,  3'd0, 8'h00, 9'd0, 3'd0},
    '{8'h00, 1'b0, 1'b1, KIND_CLOSE, 3'd0, 8'h00, 9'd1, 3'd1},
    '{8'hFF, 1'b1, 1'b1, KIND_DONE,  3'd0, 8'h00, 9'd0, 3'd1}
  };

  parameter_fragment_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_msg_byte      (in_msg_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_param_slot   (out_param_slot),
    .out_byte_value   (out_byte_value),
    .out_param_length (out_param_length),
    .out_params_seen  (out_params_seen),
    .out_run_end      (out_run_end)
  );

  always #6 clk = ~clk;

  function automatic void add_result(pfd_kind_t k, int slot, logic [7:0] v, int len,
                                     int seen);
    pfd_result_t r;
    r.kind       = k;
    r.slot       = 3'(slot);
    r.byte_value = v;
    r.length     = 9'(len);
    r.seen       = 3'(seen);
    r.run_end    = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void close_param();
    add_result(KIND_CLOSE, slots_closed, 8'h00, kept, slots_closed + 1);
    slots_closed++;
    open_slot = 1'b0;
    kept      = 0;
    frag_left = 0;
    frag_last = 1'b0;
  endfunction

  // one message byte through the decoder model; results land in byte_results
  function automatic bit decode_byte(logic [7:0] b, logic f);
    bit skipped;
    int room;
    skipped = (ph == P_SKIP) && !f;
    byte_results.delete();
    case (ph)
      P_TYPE: begin
        add_result(KIND_TYPE, 0, b, 0, slots_closed);
        ph = P_HEADER;
      end
      P_HEADER: begin
        if (b == 8'h00) begin
          if (open_slot) close_param();
          ph = P_SKIP;
        end else if (!open_slot && slots_closed >= MAX_PARAMS_DEF) begin
          ph = P_SKIP;
        end else begin
          if (!open_slot) begin
            open_slot = 1'b1;
            kept      = 0;
          end
          frag_left = int'(b & FRAG_LEN_MASK);
          frag_last = (b & FRAG_LAST_BIT) != 8'h00;
          if (frag_left == 0) begin
            if (frag_last) close_param();
          end else begin
            ph = P_DATA;
          end
        end
      end
      P_DATA: begin
        if (kept < MAX_PARAM_BYTES_DEF) begin
          add_result(KIND_BYTE, slots_closed, b, 0, slots_closed);
          kept++;
        end
        frag_left--;
        if (frag_left == 0) begin
          ph = P_HEADER;
          if (frag_last) close_param();
        end
      end
      default: ;
    endcase
    if (f) begin
      if (ph == P_DATA && frag_left > 0) begin
        // bytes cut off by the end count as padding, saturating
        room = MAX_PARAM_BYTES_DEF - kept;
        kept += (frag_left < room) ? frag_left : room;
        close_param();
      end else if (open_slot) begin
        close_param();
      end
      add_result(KIND_DONE, 0, 8'h00, 0, slots_closed);
      ph           = P_TYPE;
      slots_closed = 0;
      frag_left    = 0;
      frag_last    = 1'b0;
      kept         = 0;
      open_slot    = 1'b0;
    end
    if (byte_results.size() > 0) byte_results[$].run_end = 1'b1;
    return skipped;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f, input bit typed,
                           input pfd_result_t typed_res, output bit skipped);
    pfd_result_t r;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_msg_byte   <= b;
    in_final_byte <= f;
    do @(posedge clk); while (in_stall);
    skipped = decode_byte(b, f);
    if (typed) begin
      r = typed_res;
      r.run_end = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    msg_byte_t m;
    m.b = b;
    m.f = 1'b0;
    message.push_back(m);
  endtask

  task automatic build_random_message();
    int np;
    int nf;
    int len;
    int ending;
    int cut;
    logic [7:0] hdr;
    message.delete();
    push_byte(8'($urandom));
    np = $urandom_range(0, 6);
    for (int p = 0; p < np; p++) begin
      nf = $urandom_range(1, 3);
      for (int fr = 0; fr < nf; fr++) begin
        len = ($urandom_range(0, 9) == 0) ? 63 : $urandom_range(0, 6);
        hdr = 8'(len) | ((fr == nf - 1) ? FRAG_LAST_BIT : 8'h00)
              | ($urandom_range(0, 1) ? 8'h40 : 8'h00);
        push_byte(hdr);
        repeat (len) push_byte(8'($urandom));
      end
    end
    ending = $urandom_range(0, 9);
    if (ending == 4 || ending == 5) begin
      // zero header, then trailing bytes that must be ignored
      push_byte(8'h00);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
    end else if ((ending == 6 || ending == 7) && message.size() > 1) begin
      cut = $urandom_range(1, message.size() - 1);
      message = message[0:cut-1];
    end else if (ending == 8) begin
      repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
    end
    message[$].f = 1'b1;
  endtask

  // four full fragments, then one cut short past the byte limit
  task automatic build_overflow_message();
    message.delete();
    push_byte(8'($urandom));
    repeat (4) begin
      push_byte(8'h3F);
      repeat (63) push_byte(8'($urandom));
    end
    push_byte(8'h3F);
    repeat (10) push_byte(8'($urandom));
    message[$].f = 1'b1;
  endtask

  task automatic send_message(inout int count);
    pfd_result_t none;
    bit skipped;
    none = '0;
    foreach (message[i]) begin
      send_byte(message[i].b, message[i].f, 1'b0, none, skipped);
      if (!skipped) count++;
    end
  endtask

  initial begin
    pfd_result_t r;
    bit skipped;
    int count;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r.kind       = dir_rows[i].kind;
      r.slot       = dir_rows[i].slot;
      r.byte_value = dir_rows[i].value;
      r.length     = dir_rows[i].len;
      r.seen       = dir_rows[i].seen;
      r.run_end    = 1'b0;
      send_byte(dir_rows[i].b, dir_rows[i].f, dir_rows[i].typed, r, skipped);
    end
    in_valid <= 1'b0;
    drain_results();

    count = 0;
    build_overflow_message();
    send_message(count);
    while (count < ITEM_TARGET) begin
      bursts_on = (count < QUIET_FROM) && ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        drain_results();
      end
      build_random_message();
      send_message(count);
    end
    bursts_on = 1'b0;
    in_valid <= 1'b0;
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    forever begin
      if (bursts_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    pfd_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: kind %0d slot %0d byte %h len %0d seen %0d",
                   out_result_kind, out_param_slot, out_byte_value, out_param_length,
                   out_params_seen);
      end else begin
        e = pending_results.pop_front();
        if (out_result_kind !== e.kind || out_param_slot !== e.slot
            || out_byte_value !== e.byte_value || out_param_length !== e.length
            || out_params_seen !== e.seen || out_run_end !== e.run_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind %0d slot %0d byte %h len %0d seen %0d end %0d, %s",
                     e.kind, e.slot, e.byte_value, e.length, e.seen, e.run_end,
                     $sformatf("got kind %0d slot %0d byte %h len %0d seen %0d end %0d",
                               out_result_kind, out_param_slot, out_byte_value,
                               out_param_length, out_params_seen, out_run_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
